// File: rtl/pid_controller_back_calc_core_defines.svh
// ----------------------------------------------------------------------------
// PID core assertion macros
// Concurrent check wrappers; NO_ASSERTIONS compiles them out.
// ----------------------------------------------------------------------------
`ifndef PID_CONTROLLER_BACK_CALC_CORE_DEFINES_SVH
`define PID_CONTROLLER_BACK_CALC_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define PCBC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
    else $error("pcbc check failed");
`define PCBC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("pcbc check failed");
`else
`define PCBC_ASSERT(lbl, clk, rstn, prop)
`define PCBC_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// File: rtl/pcbc_pkg.sv
// ----------------------------------------------------------------------------
// PID core package
// Shared types, register codes and fixed constants.
// ----------------------------------------------------------------------------
package pcbc_pkg;

  localparam int DT_FRAC = 16;
  localparam int ALPHA_FRAC = 16;
  localparam logic [16:0] ALPHA_ONE = 17'h10000;

  typedef enum logic [3:0] {
    REG_PROP_GAIN  = 4'd0,
    REG_INTEG_GAIN = 4'd1,
    REG_DERIV_GAIN = 4'd2,
    REG_ALPHA      = 4'd3,
    REG_INTEG_LOW  = 4'd4,
    REG_INTEG_HIGH = 4'd5,
    REG_DRIVE_LOW  = 4'd6,
    REG_DRIVE_HIGH = 4'd7
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROP,
    ST_INTEG,
    ST_DERIV,
    ST_FILT,
    ST_DGAIN,
    ST_IGAIN,
    ST_SUM,
    ST_BACK,
    ST_OUT
  } pid_state_e;

  typedef struct packed {
    logic start;
    logic sel_dt;
  } unit_ctrl_t;

endpackage

// File: rtl/pcbc_mul.sv
// ----------------------------------------------------------------------------
// PID core serial multiplier
// Shift-add over one multiplier bit per cycle, then round and saturate.
// ----------------------------------------------------------------------------
module pcbc_mul #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pcbc_pkg::unit_ctrl_t          ctrl_i,
  input  logic signed [DATA_WIDTH+1:0]  a_i,
  input  logic signed [DATA_WIDTH+1:0]  b_i,
  output logic                          done_o,
  output logic signed [DATA_WIDTH-1:0]  result_o
);

  localparam int W  = DATA_WIDTH;
  localparam int OW = DATA_WIDTH + 2;
  localparam int PW = 2 * OW + 2;
  localparam int CW = $clog2(OW + 1);
  localparam logic signed [PW-1:0] DMAXP = $signed({{(PW-W+1){1'b0}}, {(W-1){1'b1}}});
  localparam logic signed [PW-1:0] DMINP = ~DMAXP;

  logic [OW-1:0]    ua_q;
  logic [2*OW-1:0]  prod_q;
  logic             neg_q, sel_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q, fin_q, done_q;
  logic signed [W-1:0] res_q;

  logic [OW:0]            sum;
  logic signed [PW-1:0]   prod_ext, sval, half, rnd, shd;
  logic signed [W-1:0]    sat_res;

  assign sum = {1'b0, prod_q[2*OW-1:OW]} + (prod_q[0] ? {1'b0, ua_q} : {(OW+1){1'b0}});

  always_comb begin
    prod_ext = $signed({2'b00, prod_q});
    sval     = neg_q ? -prod_ext : prod_ext;
    half     = sel_q ? (PW'(1) <<< (pcbc_pkg::DT_FRAC - 1)) : (PW'(1) <<< (FRAC_BITS - 1));
    rnd      = sval + half;
    shd      = sel_q ? (rnd >>> pcbc_pkg::DT_FRAC) : (rnd >>> FRAC_BITS);
    if (shd > DMAXP) begin
      sat_res = DMAXP[W-1:0];
    end else if (shd < DMINP) begin
      sat_res = DMINP[W-1:0];
    end else begin
      sat_res = shd[W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(OW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end else if (fin_q) begin
        fin_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      ua_q   <= a_i[OW-1] ? unsigned'(-a_i) : unsigned'(a_i);
      prod_q <= {{OW{1'b0}}, (b_i[OW-1] ? unsigned'(-b_i) : unsigned'(b_i))};
      neg_q  <= a_i[OW-1] ^ b_i[OW-1];
      sel_q  <= ctrl_i.sel_dt;
    end else if (busy_q) begin
      prod_q <= {sum, prod_q[OW-1:1]};
    end
    if (fin_q) begin
      res_q <= sat_res;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

// File: rtl/pcbc_div.sv
// ----------------------------------------------------------------------------
// PID core serial divider
// Restoring division, one quotient bit per cycle, truncate and saturate.
// ----------------------------------------------------------------------------
module pcbc_div #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pcbc_pkg::unit_ctrl_t          ctrl_i,
  input  logic [DATA_WIDTH-1:0]         num_i,
  input  logic [DATA_WIDTH-1:0]         den_i,
  input  logic                          neg_i,
  output logic                          done_o,
  output logic signed [DATA_WIDTH-1:0]  result_o
);

  localparam int W   = DATA_WIDTH;
  localparam int SHM = (FRAC_BITS > pcbc_pkg::DT_FRAC) ? FRAC_BITS : pcbc_pkg::DT_FRAC;
  localparam int ND  = W + SHM;
  localparam int CW  = $clog2(ND + 1);
  localparam logic [ND-1:0] DMAXU = {{(SHM+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [ND-1:0] HALFU = {{SHM{1'b0}}, 1'b1, {(W-1){1'b0}}};

  logic [ND-1:0] dq_q;
  logic [W-1:0]  rem_q, den_q;
  logic          neg_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, fin_q, done_q;
  logic signed [W-1:0] res_q;

  logic [W:0]          trial, diff;
  logic                ge;
  logic signed [W-1:0] sat_res;

  always_comb begin
    trial = {rem_q, dq_q[ND-1]};
    diff  = trial - {1'b0, den_q};
    ge    = trial >= {1'b0, den_q};
    if (neg_q) begin
      sat_res = (dq_q > HALFU) ? $signed(HALFU[W-1:0]) : -$signed(dq_q[W-1:0]);
    end else begin
      sat_res = (dq_q > DMAXU) ? $signed(DMAXU[W-1:0]) : $signed(dq_q[W-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(ND);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end else if (fin_q) begin
        fin_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      dq_q  <= ctrl_i.sel_dt ? (ND'(num_i) << pcbc_pkg::DT_FRAC) : (ND'(num_i) << FRAC_BITS);
      rem_q <= '0;
      den_q <= den_i;
      neg_q <= neg_i;
    end else if (busy_q) begin
      // shift the next dividend bit in, keep the quotient bit at the bottom
      rem_q <= ge ? diff[W-1:0] : trial[W-1:0];
      dq_q  <= {dq_q[ND-2:0], ge};
    end
    if (fin_q) begin
      res_q <= sat_res;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

// File: rtl/pid_controller_back_calc_core.sv
// A request runs from acceptance to result through the serial multiplier and divider in turn;
// the back-calculation division runs only when the sum is clamped and the integral gain is
// nonzero. No request is taken while one is in progress; the next one is taken in the cycle
// after the result leaves. A zero interval or an invalid sample skips the computation.
// Output stalls hold the result and delay the next request.
// Reset clears the controller state and the output register and sets the configuration to its defaults.
// ----------------------------------------------------------------------------
// PID controller core with back-calculation anti-windup
// Sequencer around a shared serial multiplier and a shared serial divider.
// ----------------------------------------------------------------------------
`include "pid_controller_back_calc_core_defines.svh"

module pid_controller_back_calc_core #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16,
  localparam int CFG_WIDTH = (DATA_WIDTH > 17) ? DATA_WIDTH : 17
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [3:0]                    cfg_index_i,
  input  logic [CFG_WIDTH-1:0]          cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [DATA_WIDTH-1:0]  error_sample_i,
  input  logic [15:0]                   sample_interval_i,
  input  logic                          sample_invalid_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [DATA_WIDTH-1:0]  drive_value_o
);

  localparam int W  = DATA_WIDTH;
  localparam int OW = DATA_WIDTH + 2;
  localparam logic signed [W+1:0] DMAX2 = $signed({3'b000, {(W-1){1'b1}}});
  localparam logic signed [W+1:0] DMIN2 = ~DMAX2;

  typedef logic signed [W-1:0] data_t;

  function automatic logic signed [W+1:0] sx2(input logic signed [W-1:0] x);
    return {{2{x[W-1]}}, x};
  endfunction

  function automatic logic signed [W-1:0] sat2(input logic signed [W+1:0] x);
    logic signed [W-1:0] r;
    if (x > DMAX2) begin
      r = DMAX2[W-1:0];
    end else if (x < DMIN2) begin
      r = DMIN2[W-1:0];
    end else begin
      r = x[W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [W+1:0] clamp2(input logic signed [W+1:0] x,
                                                 input logic signed [W-1:0] lo,
                                                 input logic signed [W-1:0] hi);
    logic signed [W+1:0] r;
    if (x < sx2(lo)) begin
      r = sx2(lo);
    end else if (x > sx2(hi)) begin
      r = sx2(hi);
    end else begin
      r = x;
    end
    return r;
  endfunction

  function automatic logic [W-1:0] mag(input logic signed [W-1:0] x);
    return x[W-1] ? unsigned'(-x) : unsigned'(x);
  endfunction

  // configuration
  data_t       kp_q, ki_q, kd_q, ilo_q, ihi_q, dlo_q, dhi_q;
  logic [16:0] alpha_q, alpha_c;

  // controller state and per-request working values
  data_t       integ_q, prev_q, filt_q, held_q, out_q;
  data_t       e_q, p_q, draw_q, dterm_q, iterm_q;
  logic [15:0] dt_q;

  pcbc_pkg::pid_state_e state_q, state_d;
  logic                 launch_q, launch_d;

  pcbc_pkg::unit_ctrl_t    mul_ctrl, div_ctrl;
  logic signed [OW-1:0]    mul_a, mul_b;
  logic                    mul_done, div_done;
  data_t                   mul_res, div_res;
  logic [W-1:0]            div_num, div_den;
  logic                    div_neg;

  data_t               diff_e, diff_f, usat, nback;
  logic signed [W+1:0] usum, uclamp, integ_new, integ_bc;
  logic                backcalc;

  assign cfg_ready_o = 1'b1;
  assign alpha_c     = (alpha_q > pcbc_pkg::ALPHA_ONE) ? pcbc_pkg::ALPHA_ONE : alpha_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q    <= '0;
      ki_q    <= '0;
      kd_q    <= '0;
      alpha_q <= pcbc_pkg::ALPHA_ONE;
      ilo_q   <= DMIN2[W-1:0];
      ihi_q   <= DMAX2[W-1:0];
      dlo_q   <= DMIN2[W-1:0];
      dhi_q   <= DMAX2[W-1:0];
    end else if (cfg_valid_i) begin
      case (pcbc_pkg::cfg_reg_e'(cfg_index_i))
        pcbc_pkg::REG_PROP_GAIN:  kp_q    <= cfg_data_i[W-1:0];
        pcbc_pkg::REG_INTEG_GAIN: ki_q    <= cfg_data_i[W-1:0];
        pcbc_pkg::REG_DERIV_GAIN: kd_q    <= cfg_data_i[W-1:0];
        pcbc_pkg::REG_ALPHA:      alpha_q <= cfg_data_i[16:0];
        pcbc_pkg::REG_INTEG_LOW:  ilo_q   <= cfg_data_i[W-1:0];
        pcbc_pkg::REG_INTEG_HIGH: ihi_q   <= cfg_data_i[W-1:0];
        pcbc_pkg::REG_DRIVE_LOW:  dlo_q   <= cfg_data_i[W-1:0];
        pcbc_pkg::REG_DRIVE_HIGH: dhi_q   <= cfg_data_i[W-1:0];
        default: ;
      endcase
    end
  end

  // combinational datapath around the units
  always_comb begin
    diff_e    = sat2(sx2(e_q) - sx2(prev_q));
    diff_f    = sat2(sx2(draw_q) - sx2(filt_q));
    usum      = sx2(p_q) + sx2(iterm_q) + sx2(dterm_q);
    uclamp    = clamp2(usum, dlo_q, dhi_q);
    usat      = uclamp[W-1:0];
    backcalc  = (ki_q != '0) && (uclamp != usum);
    nback     = sat2(sx2(out_q) - sx2(p_q) - sx2(dterm_q));
    integ_new = clamp2(sx2(sat2(sx2(integ_q) + sx2(mul_res))), ilo_q, ihi_q);
    integ_bc  = clamp2(sx2(div_res), ilo_q, ihi_q);
  end

  always_comb begin
    mul_ctrl.start  = 1'b0;
    mul_ctrl.sel_dt = 1'b0;
    mul_a           = '0;
    mul_b           = '0;
    div_ctrl.start  = 1'b0;
    div_ctrl.sel_dt = 1'b0;
    div_num         = mag(diff_e);
    div_den         = W'(dt_q);
    div_neg         = diff_e[W-1];
    case (state_q)
      pcbc_pkg::ST_PROP: begin
        mul_ctrl.start = launch_q;
        mul_a          = sx2(kp_q);
        mul_b          = sx2(e_q);
      end
      pcbc_pkg::ST_INTEG: begin
        mul_ctrl.start  = launch_q;
        mul_ctrl.sel_dt = 1'b1;
        mul_a           = sx2(e_q);
        mul_b           = $signed(OW'(dt_q));
      end
      pcbc_pkg::ST_DERIV: begin
        div_ctrl.start  = launch_q;
        div_ctrl.sel_dt = 1'b1;
      end
      pcbc_pkg::ST_FILT: begin
        mul_ctrl.start  = launch_q;
        mul_ctrl.sel_dt = 1'b1;
        mul_a           = $signed(OW'(alpha_c));
        mul_b           = sx2(diff_f);
      end
      pcbc_pkg::ST_DGAIN: begin
        mul_ctrl.start = launch_q;
        mul_a          = sx2(kd_q);
        mul_b          = sx2(filt_q);
      end
      pcbc_pkg::ST_IGAIN: begin
        mul_ctrl.start = launch_q;
        mul_a          = sx2(ki_q);
        mul_b          = sx2(integ_q);
      end
      pcbc_pkg::ST_BACK: begin
        div_ctrl.start = launch_q;
        div_num        = mag(nback);
        div_den        = mag(ki_q);
        div_neg        = nback[W-1] ^ ki_q[W-1];
      end
      default: ;
    endcase
  end

  pcbc_mul #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mul_ctrl),
    .a_i      (mul_a),
    .b_i      (mul_b),
    .done_o   (mul_done),
    .result_o (mul_res)
  );

  pcbc_div #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (div_ctrl),
    .num_i    (div_num),
    .den_i    (div_den),
    .neg_i    (div_neg),
    .done_o   (div_done),
    .result_o (div_res)
  );

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= pcbc_pkg::ST_IDLE;
      launch_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      launch_q <= launch_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    launch_d = 1'b0;
    case (state_q)
      pcbc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (sample_interval_i == 16'd0 || sample_invalid_i) begin
            state_d = pcbc_pkg::ST_OUT;
          end else begin
            state_d  = pcbc_pkg::ST_PROP;
            launch_d = 1'b1;
          end
        end
      end
      pcbc_pkg::ST_PROP: begin
        if (mul_done) begin
          state_d  = pcbc_pkg::ST_INTEG;
          launch_d = 1'b1;
        end
      end
      pcbc_pkg::ST_INTEG: begin
        if (mul_done) begin
          state_d  = pcbc_pkg::ST_DERIV;
          launch_d = 1'b1;
        end
      end
      pcbc_pkg::ST_DERIV: begin
        if (div_done) begin
          state_d  = pcbc_pkg::ST_FILT;
          launch_d = 1'b1;
        end
      end
      pcbc_pkg::ST_FILT: begin
        if (mul_done) begin
          state_d  = pcbc_pkg::ST_DGAIN;
          launch_d = 1'b1;
        end
      end
      pcbc_pkg::ST_DGAIN: begin
        if (mul_done) begin
          state_d  = pcbc_pkg::ST_IGAIN;
          launch_d = 1'b1;
        end
      end
      pcbc_pkg::ST_IGAIN: begin
        if (mul_done) begin
          state_d = pcbc_pkg::ST_SUM;
        end
      end
      pcbc_pkg::ST_SUM: begin
        if (backcalc) begin
          state_d  = pcbc_pkg::ST_BACK;
          launch_d = 1'b1;
        end else begin
          state_d = pcbc_pkg::ST_OUT;
        end
      end
      pcbc_pkg::ST_BACK: begin
        if (div_done) begin
          state_d = pcbc_pkg::ST_OUT;
        end
      end
      pcbc_pkg::ST_OUT: begin
        if (!out_stall_i) begin
          state_d = pcbc_pkg::ST_IDLE;
        end
      end
      default: state_d = pcbc_pkg::ST_IDLE;
    endcase
  end

  // controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      prev_q  <= '0;
      filt_q  <= '0;
      held_q  <= '0;
      out_q   <= '0;
    end else begin
      case (state_q)
        pcbc_pkg::ST_IDLE: begin
          if (in_valid_i) begin
            if (sample_interval_i == 16'd0) begin
              out_q <= '0;
            end else if (sample_invalid_i) begin
              out_q <= held_q;
            end
          end
        end
        pcbc_pkg::ST_INTEG: begin
          if (mul_done) begin
            integ_q <= integ_new[W-1:0];
          end
        end
        pcbc_pkg::ST_DERIV: begin
          if (div_done) begin
            prev_q <= e_q;
          end
        end
        pcbc_pkg::ST_FILT: begin
          if (mul_done) begin
            filt_q <= sat2(sx2(filt_q) + sx2(mul_res));
          end
        end
        pcbc_pkg::ST_SUM: begin
          out_q  <= usat;
          held_q <= usat;
        end
        pcbc_pkg::ST_BACK: begin
          if (div_done) begin
            integ_q <= integ_bc[W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // working values, no reset needed
  always_ff @(posedge clk_i) begin
    if (state_q == pcbc_pkg::ST_IDLE && in_valid_i) begin
      e_q  <= error_sample_i;
      dt_q <= sample_interval_i;
    end
    if (state_q == pcbc_pkg::ST_PROP && mul_done) begin
      p_q <= mul_res;
    end
    if (state_q == pcbc_pkg::ST_DERIV && div_done) begin
      draw_q <= div_res;
    end
    if (state_q == pcbc_pkg::ST_DGAIN && mul_done) begin
      dterm_q <= mul_res;
    end
    if (state_q == pcbc_pkg::ST_IGAIN && mul_done) begin
      iterm_q <= mul_res;
    end
  end

  assign in_stall_o    = (state_q != pcbc_pkg::ST_IDLE);
  assign out_valid_o   = (state_q == pcbc_pkg::ST_OUT);
  assign drive_value_o = out_q;

  `PCBC_ASSERT(a_no_accept_while_result, clk_i, rst_ni, out_valid_o |-> in_stall_o)
  `PCBC_ASSERT_ALWAYS(a_units_exclusive, clk_i, !(mul_done && div_done))
  `PCBC_ASSERT(a_zero_interval_gives_zero, clk_i, rst_ni,
    (in_valid_i && !in_stall_o && sample_interval_i == 16'd0) |=> (out_valid_o && drive_value_o == '0))

endmodule
